@@ rtl/rmh_pkg.sv @@
`timescale 1ns / 1ps

package rmh_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 11;

    // Operations a chain of sorted cells can perform
    localparam logic [1:0] OP_HOLD     = 2'd0;
    localparam logic [1:0] OP_INSERT   = 2'd1;
    localparam logic [1:0] OP_PUSH_TOP = 2'd2;
    localparam logic [1:0] OP_POP_TOP  = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [DATA_W-1:0] data;
    } rmh_cmd_t;

endpackage

@@ rtl/running_median_two_heaps_top.sv @@
`timescale 1ns / 1ps
// Each accepted request passes in order through insert into one cell chain,
// rebalance move between chains and result load. A new request is accepted only
// in idle, once the previous one has loaded its result; a dropped request (storage
// full) skips insert and rebalance and goes straight to the result load.
// The result load waits while the previous result is not yet taken.
// Reset (rst_n low, asynchronous) empties both halves and clears control state.
module running_median_two_heaps_top
    import rmh_pkg::*;
#(
    parameter int CAPACITY = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [DATA_W-1:0]  value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DATA_W-1:0]  median,
    output logic [COUNT_W-1:0] count,
    output logic               dropped
);

    localparam int DEPTH  = (CAPACITY + 1) / 2 + 1;
    localparam int SIZE_W = $clog2(DEPTH + 1);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS  = 2'd1;
    localparam logic [1:0] S_BAL  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [DATA_W-1:0]  val_reg, val_next;
    logic [SIZE_W-1:0]  lsize_reg, lsize_next;
    logic [SIZE_W-1:0]  usize_reg, usize_next;
    logic               drop_reg, drop_next;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  median_reg, median_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               dropped_reg, dropped_next;

    rmh_cmd_t           lcmd, ucmd;
    logic [DATA_W-1:0]  ltop, utop;
    logic [CNT_W-1:0]   total;
    logic [SIZE_W:0]    lsize_p1, usize_p1;
    logic               to_upper;
    logic               accept;
    logic               out_free;

    // Lower half: descending chain (max at head); upper half: ascending
    rmh_chain #(
        .DEPTH  (DEPTH),
        .SIZE_W (SIZE_W),
        .IS_MAX (1'b1)
    ) u_lower (
        .clk  (clk),
        .cmd  (lcmd),
        .size (lsize_reg),
        .top  (ltop)
    );

    rmh_chain #(
        .DEPTH  (DEPTH),
        .SIZE_W (SIZE_W),
        .IS_MAX (1'b0)
    ) u_upper (
        .clk  (clk),
        .cmd  (ucmd),
        .size (usize_reg),
        .top  (utop)
    );

    assign total    = CNT_W'(lsize_reg) + CNT_W'(usize_reg);
    assign lsize_p1 = {1'b0, lsize_reg} + {{SIZE_W{1'b0}}, 1'b1};
    assign usize_p1 = {1'b0, usize_reg} + {{SIZE_W{1'b0}}, 1'b1};
    assign to_upper = (usize_reg != '0) ? (val_reg > utop)
                                        : ((lsize_reg != '0) && (val_reg > ltop));
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Sequencer: insert, rebalance, then load the result register (a drop skips to the load)
    always_comb
    begin
        state_next     = state_reg;
        val_next       = val_reg;
        lsize_next     = lsize_reg;
        usize_next     = usize_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && !out_ready;
        median_next    = median_reg;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        lcmd.op        = OP_HOLD;
        lcmd.data      = val_reg;
        ucmd.op        = OP_HOLD;
        ucmd.data      = val_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    val_next = value;
                    if (total >= CAP_CNT)
                    begin
                        drop_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        drop_next  = 1'b0;
                        state_next = S_INS;
                    end
                end
            end
            S_INS:
            begin
                if (to_upper)
                begin
                    ucmd.op    = OP_INSERT;
                    usize_next = usize_p1[SIZE_W-1:0];
                end
                else
                begin
                    lcmd.op    = OP_INSERT;
                    lsize_next = lsize_p1[SIZE_W-1:0];
                end
                state_next = S_BAL;
            end
            S_BAL:
            begin
                // Move one head across when the halves differ by two
                if ({1'b0, usize_reg} > lsize_p1)
                begin
                    ucmd.op    = OP_POP_TOP;
                    lcmd.op    = OP_PUSH_TOP;
                    lcmd.data  = utop;
                    usize_next = usize_reg - SIZE_W'(1);
                    lsize_next = lsize_p1[SIZE_W-1:0];
                end
                else if ({1'b0, lsize_reg} > usize_p1)
                begin
                    lcmd.op    = OP_POP_TOP;
                    ucmd.op    = OP_PUSH_TOP;
                    ucmd.data  = ltop;
                    lsize_next = lsize_reg - SIZE_W'(1);
                    usize_next = usize_p1[SIZE_W-1:0];
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    if ({1'b0, usize_reg} == lsize_p1)
                        median_next = utop;
                    else if (lsize_reg == '0)
                        median_next = '0;
                    else
                        median_next = ltop;
                    count_next     = COUNT_W'(total);
                    dropped_next   = drop_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lsize_reg     <= '0;
            usize_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lsize_reg     <= lsize_next;
            usize_reg     <= usize_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        val_reg     <= val_next;
        drop_reg    <= drop_next;
        median_reg  <= median_next;
        count_reg   <= count_next;
        dropped_reg <= dropped_next;
    end

    assign out_valid = out_valid_reg;
    assign median    = median_reg;
    assign count     = count_reg;
    assign dropped   = dropped_reg;

endmodule

@@ rtl/rmh_cell.sv @@
`timescale 1ns / 1ps

// One slot of a sorted chain. Slot 0 is the top (max for the lower half,
// min for the upper half); contents are ordered away from the top.
module rmh_cell
    import rmh_pkg::*;
#(
    parameter int INDEX  = 0,
    parameter int SIZE_W = 10,
    parameter bit IS_MAX = 1'b1
)
(
    input  logic              clk,
    input  rmh_cmd_t          cmd,
    input  logic [SIZE_W-1:0] size,
    input  logic [DATA_W-1:0] prev_val,
    input  logic              prev_keep,
    input  logic [DATA_W-1:0] next_val,
    output logic [DATA_W-1:0] val,
    output logic              keep
);

    localparam logic [SIZE_W-1:0] IDX = SIZE_W'(INDEX);

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;
    logic              occupied;

    // A slot keeps its value on insert if it is filled and ranks at or above the new value
    assign occupied = (IDX < size);
    assign keep     = occupied &&
                      (IS_MAX ? (val_reg >= cmd.data) : (val_reg <= cmd.data));

    always_comb
    begin
        case (cmd.op)
            OP_INSERT:
            begin
                if (keep)
                    val_next = val_reg;
                else if (prev_keep)
                    val_next = cmd.data;
                else
                    val_next = prev_val;
            end
            OP_PUSH_TOP: val_next = prev_val;
            OP_POP_TOP:  val_next = next_val;
            default:     val_next = val_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

@@ rtl/rmh_chain.sv @@
`timescale 1ns / 1ps

// Row of sorted cells holding one half of the values; head is the heap top.
module rmh_chain
    import rmh_pkg::*;
#(
    parameter int DEPTH  = 513,
    parameter int SIZE_W = 10,
    parameter bit IS_MAX = 1'b1
)
(
    input  logic              clk,
    input  rmh_cmd_t          cmd,
    input  logic [SIZE_W-1:0] size,
    output logic [DATA_W-1:0] top
);

    logic [DATA_W-1:0] vals  [DEPTH];
    logic              keeps [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [DATA_W-1:0] p_val;
            logic              p_keep;
            logic [DATA_W-1:0] n_val;

            // Neighbor hookup; the head takes the request data directly
            if (i == 0)
            begin : g_head
                assign p_val  = cmd.data;
                assign p_keep = 1'b1;
            end
            else
            begin : g_body
                assign p_val  = vals[i-1];
                assign p_keep = keeps[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign n_val = vals[i];
            end
            else
            begin : g_mid
                assign n_val = vals[i+1];
            end

            rmh_cell #(
                .INDEX  (i),
                .SIZE_W (SIZE_W),
                .IS_MAX (IS_MAX)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .size      (size),
                .prev_val  (p_val),
                .prev_keep (p_keep),
                .next_val  (n_val),
                .val       (vals[i]),
                .keep      (keeps[i])
            );
        end
    endgenerate

    assign top = vals[0];

endmodule
